// ----- rtl/pftk_pkg.sv -----
// Package with the shared types, codes and helpers of the packet filter and source tracker.
package pftk_pkg;

    localparam logic [7:0] MAGIC_T = 8'h54;
    localparam logic [7:0] MAGIC_S = 8'h53;

    localparam logic [3:0] TYPE_PULSE  = 4'h0;
    localparam logic [3:0] TYPE_COLOUR = 4'h1;
    localparam logic [3:0] TYPE_META   = 4'h2;
    localparam logic [3:0] TYPE_END    = 4'hf;

    // Event codes.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PULSE   = 3'd1;
    localparam logic [2:0] EV_COLOUR  = 3'd2;
    localparam logic [2:0] EV_META    = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;
    localparam logic [2:0] EV_BLANK   = 3'd5;
    localparam logic [2:0] EV_CFGTICK = 3'd6;
    localparam logic [2:0] EV_UNKNOWN = 3'd7;

    // Drop reason codes.
    localparam logic [2:0] DR_OK      = 3'd0;
    localparam logic [2:0] DR_MODE    = 3'd1;
    localparam logic [2:0] DR_SHORT   = 3'd2;
    localparam logic [2:0] DR_MAGIC   = 3'd3;
    localparam logic [2:0] DR_VERSION = 3'd4;
    localparam logic [2:0] DR_SENDER  = 3'd5;
    localparam logic [2:0] DR_CLEN    = 3'd6;
    localparam logic [2:0] DR_DUP     = 3'd7;

    // Register indexes.
    localparam logic [2:0] REG_HEADER_BYTES = 3'd0;
    localparam logic [2:0] REG_COLOUR_BYTES = 3'd1;
    localparam logic [2:0] REG_STALE_MS     = 3'd2;
    localparam logic [2:0] REG_HOLD_TICKS   = 3'd3;
    localparam logic [2:0] REG_BUTTON       = 3'd4;
    localparam logic [2:0] REG_CFG_SERVICE  = 3'd5;

    typedef struct packed {
        logic [7:0]  header_bytes;
        logic [7:0]  colour_total_bytes;
        logic [31:0] stale_ms;
        logic [15:0] hold_ticks;
        logic        button_present;
        logic        config_service_enabled;
    } cfg_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic        is_tick;
        logic [47:0] mac;
        logic [3:0]  ptype;
        logic [7:0]  nonce;
        logic [7:0]  len;
        logic [31:0] now;
        logic        button;
        logic [2:0]  pre_reason;
    } item_t;

    function automatic logic is_stale(input logic [31:0] now, input logic [31:0] heard,
                                      input logic [31:0] limit);
        logic [31:0] age;
        age = now - heard;
        return age >= limit;
    endfunction

endpackage

// ----- rtl/pftk_front.sv -----
// Front end: takes input transfers and classifies the stateless header checks.
module pftk_front
    import pftk_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [47:0] s_src_mac,
    input  logic [7:0]  s_magic_first,
    input  logic [7:0]  s_magic_second,
    input  logic [7:0]  s_version_type,
    input  logic [7:0]  s_nonce,
    input  logic [7:0]  s_pkt_len,
    input  logic [31:0] s_now_ms,
    input  logic        s_button_low,
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    logic [2:0] pre;

    // Length, magic and version checks in their priority order.
    always_comb begin
        if (s_pkt_len < cfg.header_bytes) begin
            pre = DR_SHORT;
        end else if (s_magic_first != MAGIC_T || s_magic_second != MAGIC_S) begin
            pre = DR_MAGIC;
        end else if (s_version_type[7:4] != 4'h0) begin
            pre = DR_VERSION;
        end else begin
            pre = DR_OK;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.is_tick    = s_action;
        q_item.mac        = s_src_mac;
        q_item.ptype      = s_version_type[3:0];
        q_item.nonce      = s_nonce;
        q_item.len        = s_pkt_len;
        q_item.now        = s_now_ms;
        q_item.button     = s_button_low;
        q_item.pre_reason = pre;
    end

endmodule

// ----- rtl/pftk_queue.sv -----
// Two-entry queue that decouples the front end from the back end.
module pftk_queue
    import pftk_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t pop_item
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Payload slots.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/pftk_back.sv -----
// Back end: sender table, table walk, button handling and the result register.
module pftk_back
    import pftk_pkg::*;
#(
    parameter int SENDER_ENTRIES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_event_res,
    output logic [2:0] m_drop_reason,
    output logic [3:0] m_packet_type,
    output logic [5:0] m_selected_channel,
    output logic       m_config_mode,
    output logic       m_last
);

    localparam int IDX_W = (SENDER_ENTRIES > 1) ? $clog2(SENDER_ENTRIES) : 1;
    localparam int SEL_W = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENDER_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PCHK, S_WRD0, S_WALK, S_RDS2, S_FIN, S_TEV, S_OUT0, S_OUT1
    } state_t;

    state_t           state_reg;
    item_t            cur_reg;
    logic [IDX_W-1:0] sel_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       prev_nonce_reg;
    logic [15:0]      hold_reg;
    logic             press_reg;
    logic             mode_reg;
    logic [2:0]       ev0_reg;
    logic [2:0]       drop_reg;
    logic [3:0]       type_reg;
    logic             two_reg;

    // Sender table memory with a valid bit per entry.
    logic [47:0]         mac_mem   [SENDER_ENTRIES];
    logic [31:0]         heard_mem [SENDER_ENTRIES];
    logic [SENDER_ENTRIES-1:0] vld_reg;
    logic [47:0]         rd_mac_reg;
    logic [31:0]         rd_heard_reg;
    logic                rd_vld_reg;

    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [47:0]      wr_mac;
    logic [31:0]      wr_heard;

    logic [47:0]      ent_mac;
    logic [31:0]      ent_heard;
    logic [IDX_W-1:0] nxt_sel;
    logic [2:0]       fin_reason;
    logic [2:0]       fin_event;
    logic             pressed;
    logic             ev5;
    logic             mode1;
    logic             ev6;
    logic [SEL_W-1:0] sel_ext;

    assign ent_mac   = rd_vld_reg ? rd_mac_reg : 48'h0;
    assign ent_heard = rd_vld_reg ? rd_heard_reg : 32'h0;
    assign nxt_sel   = (sel_reg == LAST_IDX) ? '0 : sel_reg + 1'b1;
    assign pressed   = cfg.button_present && cur_reg.button;
    assign ev5       = pressed && (hold_reg >= cfg.hold_ticks);
    assign mode1     = ev5 || mode_reg;
    assign ev6       = mode1 && cfg.config_service_enabled;

    // Colour length and duplicate checks, then the type classification.
    always_comb begin
        if (cur_reg.ptype == TYPE_COLOUR && cur_reg.len != cfg.colour_total_bytes) begin
            fin_reason = DR_CLEN;
        end else if (cur_reg.nonce == prev_nonce_reg) begin
            fin_reason = DR_DUP;
        end else begin
            fin_reason = DR_OK;
        end
        unique case (cur_reg.ptype)
            TYPE_PULSE:  fin_event = EV_PULSE;
            TYPE_COLOUR: fin_event = EV_COLOUR;
            TYPE_META:   fin_event = EV_META;
            TYPE_END:    fin_event = EV_END;
            default:     fin_event = EV_UNKNOWN;
        endcase
    end

    // Table read address and write port, chosen by the sequencer state.
    always_comb begin
        rd_addr  = sel_reg;
        wr_en    = 1'b0;
        wr_addr  = sel_reg;
        wr_mac   = ent_mac;
        wr_heard = cur_reg.now;
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = q_item.is_tick ? nxt_sel : sel_reg;
            end
            S_PCHK: begin
                if (cur_reg.mac == ent_mac) begin
                    wr_en = 1'b1;
                end else if (ent_mac == 48'h0) begin
                    wr_en    = 1'b1;
                    wr_mac   = cur_reg.mac;
                    wr_heard = (cur_reg.ptype == TYPE_META) ? cur_reg.now : ent_heard;
                end else if (is_stale(cur_reg.now, ent_heard, cfg.stale_ms)) begin
                    wr_en    = 1'b1;
                    wr_mac   = 48'h0;
                    wr_heard = ent_heard;
                end
            end
            S_WRD0: begin
                rd_addr = '0;
            end
            S_WALK: begin
                rd_addr = idx_reg + 1'b1;
                wr_addr = idx_reg;
                if (ent_mac == cur_reg.mac) begin
                    wr_en = 1'b1;
                end else if (ent_mac == 48'h0) begin
                    wr_en  = 1'b1;
                    wr_mac = cur_reg.mac;
                end else if (is_stale(cur_reg.now, ent_heard, cfg.stale_ms)) begin
                    wr_en    = 1'b1;
                    wr_mac   = 48'h0;
                    wr_heard = ent_heard;
                end
            end
            S_FIN: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_addr = sel_reg;
            end
        endcase
    end

    // Table storage with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mac_mem[wr_addr]   <= wr_mac;
            heard_mem[wr_addr] <= wr_heard;
        end
        rd_mac_reg   <= mac_mem[rd_addr];
        rd_heard_reg <= heard_mem[rd_addr];
    end

    // Entry valid bits; an entry never written reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign q_pop = (state_reg == S_IDLE) && q_not_empty;

    // Sequencer state and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            sel_reg        <= '0;
            idx_reg        <= '0;
            prev_nonce_reg <= 8'h0;
            hold_reg       <= 16'h0;
            press_reg      <= 1'b0;
            mode_reg       <= 1'b0;
            two_reg        <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_not_empty) begin
                        cur_reg  <= q_item;
                        type_reg <= q_item.is_tick ? 4'h0 : q_item.ptype;
                        two_reg  <= 1'b0;
                        ev0_reg  <= EV_NONE;
                        if (q_item.is_tick) begin
                            state_reg <= S_TEV;
                        end else if (mode_reg) begin
                            drop_reg  <= DR_MODE;
                            state_reg <= S_OUT0;
                        end else if (q_item.pre_reason != DR_OK) begin
                            drop_reg  <= q_item.pre_reason;
                            state_reg <= S_OUT0;
                        end else begin
                            state_reg <= S_PCHK;
                        end
                    end
                end
                S_PCHK: begin
                    if (cur_reg.mac == ent_mac ||
                        (ent_mac == 48'h0 && cur_reg.ptype == TYPE_META)) begin
                        drop_reg  <= fin_reason;
                        ev0_reg   <= (fin_reason == DR_OK) ? fin_event : EV_NONE;
                        if (fin_reason == DR_OK) begin
                            prev_nonce_reg <= cur_reg.nonce;
                        end
                        state_reg <= S_OUT0;
                    end else if (ent_mac == 48'h0) begin
                        drop_reg  <= DR_SENDER;
                        state_reg <= S_OUT0;
                    end else begin
                        state_reg <= S_WRD0;
                    end
                end
                S_WRD0: begin
                    idx_reg   <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK: begin
                    if (ent_mac == cur_reg.mac || ent_mac == 48'h0 || idx_reg == LAST_IDX) begin
                        if (cur_reg.ptype == TYPE_META) begin
                            state_reg <= S_RDS2;
                        end else begin
                            drop_reg  <= DR_SENDER;
                            state_reg <= S_OUT0;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_RDS2: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    drop_reg <= fin_reason;
                    ev0_reg  <= (fin_reason == DR_OK) ? fin_event : EV_NONE;
                    if (fin_reason == DR_OK) begin
                        prev_nonce_reg <= cur_reg.nonce;
                    end
                    state_reg <= S_OUT0;
                end
                S_TEV: begin
                    drop_reg <= DR_OK;
                    if (!pressed) begin
                        hold_reg <= 16'h0;
                    end else if (!ev5) begin
                        hold_reg <= hold_reg + 16'h1;
                    end
                    if (!mode1) begin
                        mode_reg  <= 1'b0;
                        press_reg <= pressed;
                        if (pressed && !press_reg) begin
                            sel_reg <= (ent_mac == 48'h0) ? '0 : nxt_sel;
                        end
                    end else begin
                        mode_reg <= cfg.config_service_enabled;
                    end
                    ev0_reg   <= ev5 ? EV_BLANK : (ev6 ? EV_CFGTICK : EV_NONE);
                    two_reg   <= ev5 && ev6;
                    state_reg <= S_OUT0;
                end
                S_OUT0: begin
                    if (m_ready) begin
                        state_reg <= two_reg ? S_OUT1 : S_IDLE;
                    end
                end
                S_OUT1: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result channel; channel and mode reflect the state after the item.
    assign sel_ext            = SEL_W'(sel_reg);
    assign m_valid            = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign m_event_res        = (state_reg == S_OUT1) ? EV_CFGTICK : ev0_reg;
    assign m_drop_reason      = drop_reg;
    assign m_packet_type      = type_reg;
    assign m_selected_channel = sel_ext[5:0];
    assign m_config_mode      = mode_reg;
    assign m_last             = (state_reg == S_OUT1) || !two_reg;

endmodule

// ----- rtl/packet_filter_source_tracker_top.sv -----
// Top level of the packet filter and source tracker with its register port.
//
//   Channel   Direction  Handshake              Payload
//   s_*       in         s_valid / s_ready      packet header or button tick
//   m_*       out        m_valid / m_ready      one result per transfer, m_last on the final
//   APB       in/out     psel, penable, pready  six configuration registers at 4*i
//
// A tick goes through S_TEV, then one output state per result. A packet dropped by mode,
// length, magic or version goes straight to output; one from the selected sender is checked
// in S_PCHK; one from another sender walks the sender table one entry a cycle.
// Reset clears the table valid bits at once, so no clearing pass is needed.
// A two-entry queue keeps accepting, until it is full, while a result waits on m_ready.
module packet_filter_source_tracker_top
    import pftk_pkg::*;
#(
    parameter int SENDER_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [47:0] s_src_mac,
    input  logic [7:0]  s_magic_first,
    input  logic [7:0]  s_magic_second,
    input  logic [7:0]  s_version_type,
    input  logic [7:0]  s_nonce,
    input  logic [7:0]  s_pkt_len,
    input  logic [31:0] s_now_ms,
    input  logic        s_button_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [2:0]  m_drop_reason,
    output logic [3:0]  m_packet_type,
    output logic [5:0]  m_selected_channel,
    output logic        m_config_mode,
    output logic        m_last
);

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_push;
    item_t q_in;
    logic  q_pop;
    logic  q_not_empty;
    item_t q_out;

    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes           <= 8'd4;
            cfg_reg.colour_total_bytes     <= 8'd7;
            cfg_reg.stale_ms               <= 32'd30000;
            cfg_reg.hold_ticks             <= 16'd5000;
            cfg_reg.button_present         <= 1'b0;
            cfg_reg.config_service_enabled <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_HEADER_BYTES: cfg_reg.header_bytes           <= pwdata[7:0];
                REG_COLOUR_BYTES: cfg_reg.colour_total_bytes     <= pwdata[7:0];
                REG_STALE_MS:     cfg_reg.stale_ms               <= pwdata;
                REG_HOLD_TICKS:   cfg_reg.hold_ticks             <= pwdata[15:0];
                REG_BUTTON:       cfg_reg.button_present         <= pwdata[0];
                REG_CFG_SERVICE:  cfg_reg.config_service_enabled <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            REG_HEADER_BYTES: prdata = {24'h0, cfg_reg.header_bytes};
            REG_COLOUR_BYTES: prdata = {24'h0, cfg_reg.colour_total_bytes};
            REG_STALE_MS:     prdata = cfg_reg.stale_ms;
            REG_HOLD_TICKS:   prdata = {16'h0, cfg_reg.hold_ticks};
            REG_BUTTON:       prdata = {31'h0, cfg_reg.button_present};
            REG_CFG_SERVICE:  prdata = {31'h0, cfg_reg.config_service_enabled};
            default:          prdata = 32'h0;
        endcase
    end

    pftk_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_src_mac      (s_src_mac),
        .s_magic_first  (s_magic_first),
        .s_magic_second (s_magic_second),
        .s_version_type (s_version_type),
        .s_nonce        (s_nonce),
        .s_pkt_len      (s_pkt_len),
        .s_now_ms       (s_now_ms),
        .s_button_low   (s_button_low),
        .cfg            (cfg_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in)
    );

    pftk_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_out)
    );

    pftk_back #(
        .SENDER_ENTRIES (SENDER_ENTRIES)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_not_empty        (q_not_empty),
        .q_item             (q_out),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_drop_reason      (m_drop_reason),
        .m_packet_type      (m_packet_type),
        .m_selected_channel (m_selected_channel),
        .m_config_mode      (m_config_mode),
        .m_last             (m_last)
    );

endmodule

// ----- rtl/pftk_checker.sv -----
// Port-level checker for the packet filter and source tracker, with its bind.
module pftk_checker
    import pftk_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_res,
    input logic [2:0] m_drop_reason,
    input logic       m_last
);

    // A waiting result is not withdrawn.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn before transfer");

    // A non-final result is followed at once by the next one.
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("second result of an item missing");

    // A dropped packet carries no event.
    a_drop_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drop_reason != DR_OK |-> m_event_res == EV_NONE)
        else $error("dropped packet with an event");

    // A dropped packet has one result only.
    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drop_reason != DR_OK |-> m_last)
        else $error("dropped packet not final");

    // The register port never waits.
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind packet_filter_source_tracker_top pftk_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_res   (m_event_res),
    .m_drop_reason (m_drop_reason),
    .m_last        (m_last)
);
